// ===== hdl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and helpers for the sprite screen projection
// Request/result payloads, camera register set, register indexes and the
// 16-bit saturation helpers used by the transform and projection stages.
// ----------------------------------------------------------------------------
package ssp_pkg;

	// Register index port width and register indexes
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PLAYER_X   = 3'd0,
		CFG_PLAYER_Y   = 3'd1,
		CFG_VIEW_DIR_X = 3'd2,
		CFG_VIEW_DIR_Y = 3'd3,
		CFG_PLANE_X    = 3'd4,
		CFG_PLANE_Y    = 3'd5
	} cfg_idx_t;

	// 16-bit signed limits
	localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
	localparam logic signed [15:0] S16_MIN = 16'sh8000;

	// Request payload: sprite position, Q8.8
	typedef struct packed {
		logic signed [15:0] sprite_x;
		logic signed [15:0] sprite_y;
	} req_t;

	// Result payload
	typedef struct packed {
		logic               visible;
		logic signed [15:0] depth;
		logic signed [15:0] center_column;
		logic [14:0]        sprite_size;
		logic [14:0]        first_column;
		logic signed [15:0] end_column;
		logic [8:0]         first_row;
		logic [9:0]         end_row;
	} res_t;

	// Camera register set: positions Q8.8, direction and plane Q2.14
	typedef struct packed {
		logic signed [15:0] player_x;
		logic signed [15:0] player_y;
		logic signed [15:0] view_dir_x;
		logic signed [15:0] view_dir_y;
		logic signed [15:0] plane_x;
		logic signed [15:0] plane_y;
	} cam_cfg_t;

	localparam cam_cfg_t CAM_CFG_RESET = '{
		player_x:   16'sd0,
		player_y:   16'sd0,
		view_dir_x: 16'sd16384,
		view_dir_y: 16'sd0,
		plane_x:    16'sd0,
		plane_y:    16'sd10813
	};

	// Camera-space position handed from the transform to the projection
	typedef struct packed {
		logic               valid;
		logic               det_zero;
		logic signed [15:0] tx;
		logic signed [15:0] ty;
	} xform_t;

	// Saturate a 17-bit signed value to 16 bits
	function automatic logic signed [15:0] sat16(logic signed [16:0] v);
		logic signed [15:0] r;
		if (v[16] != v[15]) begin
			r = v[16] ? S16_MIN : S16_MAX;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Apply the sign to an unsigned quotient and saturate to 16 bits
	function automatic logic signed [15:0] sign_sat16(logic [15:0] quo, logic ovf, logic neg);
		logic signed [15:0] r;
		if (neg) begin
			if (ovf || quo > 16'h8000) begin
				r = S16_MIN;
			end else begin
				r = $signed(-quo);
			end
		end else begin
			if (ovf || quo[15]) begin
				r = S16_MAX;
			end else begin
				r = $signed(quo);
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/ssp_div.sv =====
// ----------------------------------------------------------------------------
// ssp_div: pipelined restoring divider
// Unsigned num / den, one quotient bit per stage, QUO_W stages. Flags an
// overflow when the quotient does not fit in QUO_W bits. A sideband word and
// a valid bit travel with each operand pair.
// ----------------------------------------------------------------------------
module ssp_div #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 16,
	parameter int QUO_W  = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output logic              ovf,
	output logic [SIDE_W-1:0] side_out
);

	localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	logic              vld_s  [QUO_W];
	logic [QUO_W-1:0]  quo_s  [QUO_W];
	logic              ovf_s  [QUO_W];
	logic [SIDE_W-1:0] side_s [QUO_W];
	logic [REM_W-1:0]  rem_s  [QUO_W-1];
	logic [DEN_W-1:0]  den_s  [QUO_W-1];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		localparam int QBIT = QUO_W - 1 - i;

		logic              vld_in;
		logic [REM_W-1:0]  rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [QUO_W-1:0]  quo_in;
		logic              ovf_in;
		logic [SIDE_W-1:0] side_w;
		logic [REM_W-1:0]  trial;
		logic              take;
		logic [QUO_W-1:0]  quo_nxt;

		if (i == 0) begin : g_head
			// first stage also checks whether the quotient fits
			assign vld_in = in_valid;
			assign rem_in = REM_W'(num);
			assign den_in = den;
			assign quo_in = '0;
			assign ovf_in = (REM_W'(num) >= (REM_W'(den) << QUO_W));
			assign side_w = side_in;
		end else begin : g_body
			assign vld_in = vld_s[i-1];
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
			assign ovf_in = ovf_s[i-1];
			assign side_w = side_s[i-1];
		end

		// try to subtract the shifted divisor
		always_comb begin
			trial         = REM_W'(den_in) << QBIT;
			take          = (rem_in >= trial);
			quo_nxt       = quo_in;
			quo_nxt[QBIT] = take;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_s[i]  <= quo_nxt;
				ovf_s[i]  <= ovf_in;
				side_s[i] <= side_w;
			end
		end

		// remainder and divisor are needed only by later stages
		if (i < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[i] <= take ? (rem_in - trial) : rem_in;
					den_s[i] <= den_in;
				end
			end
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign quo       = quo_s[QUO_W-1];
	assign ovf       = ovf_s[QUO_W-1];
	assign side_out  = side_s[QUO_W-1];

endmodule

// ===== hdl/ssp_xform.sv =====
// ----------------------------------------------------------------------------
// ssp_xform: camera-space transform
// Subtracts the player position, forms the inverse camera matrix products
// and the determinant, and divides to get lateral offset tx and depth ty in
// Q8.8, truncated toward zero and saturated to 16 bits.
// ----------------------------------------------------------------------------
module ssp_xform (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             req_acc,
	input  ssp_pkg::req_t    req,
	input  ssp_pkg::cam_cfg_t cam,
	output ssp_pkg::xform_t  xf
);

	localparam int FRAC_SHIFT = 14;
	localparam int MAG_W      = 33;
	localparam int NUM_W      = MAG_W + FRAC_SHIFT;

	logic               vld_s1;
	logic signed [15:0] dx_s1, dy_s1;

	logic               vld_s2;
	logic signed [31:0] pa_s2, pb_s2, pc_s2, pd_s2, qa_s2, qb_s2;

	logic               vld_s3;
	logic signed [32:0] nx_s3, ny_s3, det_s3;

	logic               vld_s4;
	logic [MAG_W-1:0]   nxm_s4, nym_s4, detm_s4;
	logic               txn_s4, tyn_s4, dz_s4;

	logic               vld_s21;
	logic               dz_s21;
	logic signed [15:0] tx_s21, ty_s21;

	logic [15:0]        qtx, qty;
	logic               ovtx, ovty;
	logic               txn_d;
	logic [1:0]         ty_side;
	logic               ty_vld;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s21 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= req_acc;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s21 <= ty_vld;
		end
	end

	// relative position, saturated
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= ssp_pkg::sat16(17'(req.sprite_x) - 17'(cam.player_x));
			dy_s1 <= ssp_pkg::sat16(17'(req.sprite_y) - 17'(cam.player_y));
		end
	end

	// matrix and determinant products
	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s2 <= cam.view_dir_y * dx_s1;
			pb_s2 <= cam.view_dir_x * dy_s1;
			pc_s2 <= cam.plane_x * dy_s1;
			pd_s2 <= cam.plane_y * dx_s1;
			qa_s2 <= cam.plane_x * cam.view_dir_y;
			qb_s2 <= cam.view_dir_x * cam.plane_y;
		end
	end

	// numerators and determinant
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s3  <= 33'(pa_s2) - 33'(pb_s2);
			ny_s3  <= 33'(pc_s2) - 33'(pd_s2);
			det_s3 <= 33'(qa_s2) - 33'(qb_s2);
		end
	end

	// split into sign and magnitude for the dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			nxm_s4  <= nx_s3[32] ? MAG_W'(-nx_s3) : MAG_W'(nx_s3);
			nym_s4  <= ny_s3[32] ? MAG_W'(-ny_s3) : MAG_W'(ny_s3);
			detm_s4 <= det_s3[32] ? MAG_W'(-det_s3) : MAG_W'(det_s3);
			txn_s4  <= nx_s3[32] ^ det_s3[32];
			tyn_s4  <= ny_s3[32] ^ det_s3[32];
			dz_s4   <= (det_s3 == '0);
		end
	end

	ssp_div #(
		.NUM_W  (NUM_W),
		.DEN_W  (MAG_W),
		.QUO_W  (16),
		.SIDE_W (1)
	) u_div_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s4),
		.num       ({nxm_s4, FRAC_SHIFT'(0)}),
		.den       (detm_s4),
		.side_in   (txn_s4),
		.out_valid (),
		.quo       (qtx),
		.ovf       (ovtx),
		.side_out  (txn_d)
	);

	ssp_div #(
		.NUM_W  (NUM_W),
		.DEN_W  (MAG_W),
		.QUO_W  (16),
		.SIDE_W (2)
	) u_div_ty (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s4),
		.num       ({nym_s4, FRAC_SHIFT'(0)}),
		.den       (detm_s4),
		.side_in   ({tyn_s4, dz_s4}),
		.out_valid (ty_vld),
		.quo       (qty),
		.ovf       (ovty),
		.side_out  (ty_side)
	);

	// restore signs and saturate
	always_ff @(posedge clk) begin
		if (adv) begin
			tx_s21 <= ssp_pkg::sign_sat16(qtx, ovtx, txn_d);
			ty_s21 <= ssp_pkg::sign_sat16(qty, ovty, ty_side[1]);
			dz_s21 <= ty_side[0];
		end
	end

	assign xf = '{valid: vld_s21, det_zero: dz_s21, tx: tx_s21, ty: ty_s21};

endmodule

// ===== hdl/ssp_proj.sv =====
// ----------------------------------------------------------------------------
// ssp_proj: screen projection
// From tx and ty computes the centre column and the sprite size with two
// pipelined dividers, then the one-sided clamped column and row bounds.
// ----------------------------------------------------------------------------
module ssp_proj #(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 768
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  ssp_pkg::xform_t xf,
	output logic            last_vld,
	output ssp_pkg::res_t   res_nxt
);

	localparam int HW_W   = $clog2(SCREEN_WIDTH / 2 + 1) + 1;
	localparam int PROD_W = 17 + HW_W;
	localparam int SZ_NUM = SCREEN_HEIGHT * 256;
	localparam int SZ_W   = $clog2(SZ_NUM + 1);

	localparam logic signed [HW_W-1:0] HW_C     = HW_W'(SCREEN_WIDTH / 2);
	localparam logic signed [17:0]     HALF_H_C = 18'(SCREEN_HEIGHT / 2);
	localparam logic signed [17:0]     H_MAX_C  = 18'(SCREEN_HEIGHT - 1);
	localparam logic signed [17:0]     W_MAX_C  = 18'(SCREEN_WIDTH - 1);

	logic                     vld_s22, dz_s22;
	logic signed [16:0]       sum_s22;
	logic signed [15:0]       ty_s22;

	logic                     vld_s23, dz_s23;
	logic signed [PROD_W-1:0] prod_s23;
	logic signed [15:0]       ty_s23;

	logic                     vld_s24, neg_s24, vis_s24;
	logic [PROD_W-1:0]        mag_s24;
	logic [14:0]              den_s24;
	logic signed [15:0]       depth_s24;

	logic                     vld_s41, vis_s41;
	logic signed [15:0]       center_s41, depth_s41;
	logic [14:0]              size_s41;

	logic                     c_vld;
	logic [15:0]              qc, qs;
	logic                     ovc, ovs;
	logic [16:0]              c_side;
	logic                     s_side;

	logic signed [17:0]       half, sx, ex, sy, ey;
	logic signed [17:0]       sx_c, ex_c, sy_c, ey_c;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s22 <= 1'b0;
			vld_s23 <= 1'b0;
			vld_s24 <= 1'b0;
			vld_s41 <= 1'b0;
		end else if (adv) begin
			vld_s22 <= xf.valid;
			vld_s23 <= vld_s22;
			vld_s24 <= vld_s23;
			vld_s41 <= c_vld;
		end
	end

	// centre numerator: (W/2) * (ty + tx)
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s22  <= 17'(xf.tx) + 17'(xf.ty);
			ty_s22   <= xf.ty;
			dz_s22   <= xf.det_zero;
			prod_s23 <= sum_s22 * HW_C;
			ty_s23   <= ty_s22;
			dz_s23   <= dz_s22;
		end
	end

	// sign and magnitude, visibility, reported depth
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s24   <= prod_s23[PROD_W-1] ? PROD_W'(-prod_s23) : PROD_W'(prod_s23);
			neg_s24   <= prod_s23[PROD_W-1];
			den_s24   <= ty_s23[14:0];
			vis_s24   <= !dz_s23 && !ty_s23[15] && (ty_s23 != 16'sd0);
			depth_s24 <= dz_s23 ? 16'sd0 : ty_s23;
		end
	end

	ssp_div #(
		.NUM_W  (PROD_W),
		.DEN_W  (15),
		.QUO_W  (16),
		.SIDE_W (17)
	) u_div_center (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s24),
		.num       (mag_s24),
		.den       (den_s24),
		.side_in   ({neg_s24, depth_s24}),
		.out_valid (c_vld),
		.quo       (qc),
		.ovf       (ovc),
		.side_out  (c_side)
	);

	ssp_div #(
		.NUM_W  (SZ_W),
		.DEN_W  (15),
		.QUO_W  (16),
		.SIDE_W (1)
	) u_div_size (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s24),
		.num       (SZ_W'(SZ_NUM)),
		.den       (den_s24),
		.side_in   (vis_s24),
		.out_valid (),
		.quo       (qs),
		.ovf       (ovs),
		.side_out  (s_side)
	);

	// saturate centre and size
	always_ff @(posedge clk) begin
		if (adv) begin
			center_s41 <= ssp_pkg::sign_sat16(qc, ovc, c_side[16]);
			depth_s41  <= c_side[15:0];
			size_s41   <= (ovs || qs[15]) ? 15'h7FFF : qs[14:0];
			vis_s41    <= s_side;
		end
	end

	// clamp bounds on one side each and assemble the result
	always_comb begin
		half = 18'(size_s41 >> 1);
		sy   = HALF_H_C - half;
		ey   = HALF_H_C + half;
		sx   = 18'(center_s41) - half;
		ex   = 18'(center_s41) + half;
		sy_c = sy[17] ? 18'sd0 : sy;
		ey_c = (ey > H_MAX_C) ? H_MAX_C : ey;
		sx_c = sx[17] ? 18'sd0 : sx;
		ex_c = (ex > W_MAX_C) ? W_MAX_C : ex;

		res_nxt       = '0;
		res_nxt.depth = depth_s41;
		if (vis_s41) begin
			res_nxt.visible       = 1'b1;
			res_nxt.center_column = center_s41;
			res_nxt.sprite_size   = size_s41;
			res_nxt.first_column  = sx_c[14:0];
			res_nxt.end_column    = ex_c[15:0];
			res_nxt.first_row     = sy_c[8:0];
			res_nxt.end_row       = ey_c[9:0];
		end
	end

	assign last_vld = vld_s41;

endmodule

// ===== hdl/sprite_screen_projection.sv =====
// ----------------------------------------------------------------------------
// sprite_screen_projection: sprite camera transform and screen projection
// Request channel (req_valid/req_stall/req) takes one sprite map position
// per cycle while req_stall is low. Result channel
// (res_valid/res_stall/res) returns visibility, depth, centre column,
// size and clamped column/row bounds for each request, in order. The
// camera registers (player position, view direction, camera plane) are
// written over cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write them only while no request is in flight.
// Throughput is one request per cycle while req_stall is low. Two banks
// of 16-stage dividers (tx and ty, then centre and size) set the depth of
// the pipeline.
// Reset clears all valid bits and loads the camera registers with their
// defaults. When res_stall holds a result, the pipeline keeps advancing
// until its last stage is full as well; only then is req_stall raised.
// ----------------------------------------------------------------------------
module sprite_screen_projection #(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 768
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  ssp_pkg::req_t                req,
	output logic                         res_valid,
	input  logic                         res_stall,
	output ssp_pkg::res_t                res,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ssp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                  cfg_data
);

	ssp_pkg::cam_cfg_t cam_q;
	ssp_pkg::xform_t   xf;
	ssp_pkg::res_t     res_nxt;
	ssp_pkg::res_t     res_q;
	logic              res_valid_q;
	logic              last_vld;
	logic              out_take;
	logic              adv;
	logic              req_acc;

	// camera registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q <= ssp_pkg::CAM_CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ssp_pkg::CFG_PLAYER_X:   cam_q.player_x   <= $signed(cfg_data);
				ssp_pkg::CFG_PLAYER_Y:   cam_q.player_y   <= $signed(cfg_data);
				ssp_pkg::CFG_VIEW_DIR_X: cam_q.view_dir_x <= $signed(cfg_data);
				ssp_pkg::CFG_VIEW_DIR_Y: cam_q.view_dir_y <= $signed(cfg_data);
				ssp_pkg::CFG_PLANE_X:    cam_q.plane_x    <= $signed(cfg_data);
				ssp_pkg::CFG_PLANE_Y:    cam_q.plane_y    <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// advance the pipeline unless its last stage is full and the output is held
	assign out_take  = !res_valid_q || !res_stall;
	assign adv       = !last_vld || out_take;
	assign req_stall = !adv;
	assign req_acc   = req_valid && adv;

	ssp_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.req_acc (req_acc),
		.req     (req),
		.cam     (cam_q),
		.xf      (xf)
	);

	ssp_proj #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.xf       (xf),
		.last_vld (last_vld),
		.res_nxt  (res_nxt)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_take) begin
			res_valid_q <= last_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && last_vld) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (res_valid && res_stall && last_vld))
		else $error("request stalled while the output path could move");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !last_vld) |=> !res_valid)
		else $error("result repeated after it was taken");

	a_vis_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.visible) |-> (!res.depth[15] && (res.depth != 16'sd0)))
		else $error("visible sprite with non-positive depth");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.visible) |-> ((res.center_column == 16'sd0) &&
		(res.sprite_size == 15'd0) && (res.first_column == 15'd0) &&
		(res.end_column == 16'sd0) && (res.first_row == 9'd0) && (res.end_row == 10'd0)))
		else $error("hidden sprite carries nonzero geometry");
`endif

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for sprite_screen_projection
// Sends sprite positions through the request channel under a series of
// camera settings. Each result is checked field by field against a local
// projection model. Sender bursts and receiver stalls are randomized.
// ----------------------------------------------------------------------------
module tb;

	localparam int SCREEN_W = 1024;
	localparam int SCREEN_H = 768;
	localparam int HALF_W   = SCREEN_W / 2;
	localparam int HALF_H   = SCREEN_H / 2;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_pat_t;

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	ssp_pkg::req_t                 req;
	logic                          res_valid;
	logic                          res_stall;
	ssp_pkg::res_t                 res;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [ssp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0]                   cfg_data;

	ssp_pkg::cam_cfg_t camera;
	ssp_pkg::res_t     pending_views[$];
	bit                quiet_mode   = 1'b0;
	int                burst_left   = 0;
	int                sprites_sent = 0;
	int                camera_loads = 0;
	int                results_seen = 0;
	int                visible_seen = 0;
	int                mismatches   = 0;
	stall_pat_t        stall_pat    = STALL_NONE;
	int                stall_cycle  = 0;

	sprite_screen_projection #(
		.SCREEN_WIDTH (SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bail out if the run hangs
	initial begin
		#2000000;
		$display("tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Projection model
	// ------------------------------------------------------------------
	function automatic longint clamp_s16(longint v);
		if (v > 32767) begin
			return 32767;
		end
		if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	function automatic ssp_pkg::res_t project_sprite(ssp_pkg::req_t s, ssp_pkg::cam_cfg_t c);
		longint        rel_x, rel_y, dir_x, dir_y, pln_x, pln_y, det;
		longint        lat, dep, ctr, sz, half, col0, col1, row0, row1;
		ssp_pkg::res_t p;
		p = '0;
		rel_x = clamp_s16(longint'($signed(s.sprite_x)) - longint'($signed(c.player_x)));
		rel_y = clamp_s16(longint'($signed(s.sprite_y)) - longint'($signed(c.player_y)));
		dir_x = longint'($signed(c.view_dir_x));
		dir_y = longint'($signed(c.view_dir_y));
		pln_x = longint'($signed(c.plane_x));
		pln_y = longint'($signed(c.plane_y));
		det   = pln_x * dir_y - dir_x * pln_y;
		// Flat camera: everything stays zero
		if (det == 0) begin
			return p;
		end
		lat = clamp_s16(((dir_y * rel_x - dir_x * rel_y) * 16384) / det);
		dep = clamp_s16(((pln_x * rel_y - pln_y * rel_x) * 16384) / det);
		p.depth = 16'(dep);
		// Behind or at the camera: only depth is reported
		if (dep <= 0) begin
			return p;
		end
		ctr = clamp_s16((longint'(HALF_W) * (dep + lat)) / dep);
		sz  = (longint'(SCREEN_H) * 256) / dep;
		if (sz > 32767) begin
			sz = 32767;
		end
		half = sz / 2;
		row0 = HALF_H - half;
		if (row0 < 0) begin
			row0 = 0;
		end
		row1 = HALF_H + half;
		if (row1 >= SCREEN_H) begin
			row1 = SCREEN_H - 1;
		end
		col0 = ctr - half;
		if (col0 < 0) begin
			col0 = 0;
		end
		if (col0 > 32767) begin
			col0 = 32767;
		end
		col1 = ctr + half;
		if (col1 >= SCREEN_W) begin
			col1 = SCREEN_W - 1;
		end
		col1 = clamp_s16(col1);
		p.visible       = 1'b1;
		p.center_column = 16'(ctr);
		p.sprite_size   = 15'(sz);
		p.first_column  = 15'(col0);
		p.end_column    = 16'(col1);
		p.first_row     = 9'(row0);
		p.end_row       = 10'(row1);
		return p;
	endfunction

	// ------------------------------------------------------------------
	// Random stimulus generators
	// ------------------------------------------------------------------
	function automatic ssp_pkg::cam_cfg_t random_camera();
		ssp_pkg::cam_cfg_t c;
		int                d_x, d_y, scale;
		if ($urandom_range(0, 1) == 1) begin
			c.player_x = 16'($urandom);
			c.player_y = 16'($urandom);
		end else begin
			c.player_x = 16'(int'($urandom_range(0, 8192)) - 4096);
			c.player_y = 16'(int'($urandom_range(0, 8192)) - 4096);
		end
		if ($urandom_range(0, 3) == 0) begin
			// Arbitrary basis, full range
			c.view_dir_x = 16'($urandom);
			c.view_dir_y = 16'($urandom);
			c.plane_x    = 16'($urandom);
			c.plane_y    = 16'($urandom);
		end else begin
			// Plane perpendicular to direction, random scale and handedness
			d_x   = int'($urandom_range(0, 32768)) - 16384;
			d_y   = int'($urandom_range(0, 32768)) - 16384;
			scale = int'($urandom_range(4, 24));
			if ($urandom_range(0, 1) == 1) begin
				scale = -scale;
			end
			c.view_dir_x = 16'(d_x);
			c.view_dir_y = 16'(d_y);
			c.plane_x    = 16'(-d_y * scale / 16);
			c.plane_y    = 16'(d_x * scale / 16);
		end
		return c;
	endfunction

	function automatic ssp_pkg::req_t random_sprite(ssp_pkg::cam_cfg_t c);
		ssp_pkg::req_t s;
		int            pick, span;
		pick = int'($urandom_range(0, 9));
		if (pick >= 7 && pick <= 8) begin
			s.sprite_x = 16'($urandom);
			s.sprite_y = 16'($urandom);
		end else begin
			span = (pick == 9) ? 8 : 3072;
			s.sprite_x = c.player_x + 16'(int'($urandom_range(0, 2 * span)) - span);
			s.sprite_y = c.player_y + 16'(int'($urandom_range(0, 2 * span)) - span);
		end
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Request and configuration drivers
	// ------------------------------------------------------------------
	task automatic send_sprite(ssp_pkg::req_t s);
		int gap;
		// Open a new burst, idling first for a random gap
		if (!quiet_mode && burst_left == 0) begin
			gap        = int'($urandom_range(0, 8));
			burst_left = int'($urandom_range(1, 24));
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req       <= s;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		pending_views.push_back(project_sprite(s, camera));
		if (burst_left > 0) begin
			burst_left--;
		end
		sprites_sent++;
	endtask

	// Drop valid and wait for every request to come back
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_views.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic put_reg(ssp_pkg::cfg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic load_camera(ssp_pkg::cam_cfg_t nc);
		settle();
		put_reg(ssp_pkg::CFG_PLAYER_X, nc.player_x);
		put_reg(ssp_pkg::CFG_PLAYER_Y, nc.player_y);
		put_reg(ssp_pkg::CFG_VIEW_DIR_X, nc.view_dir_x);
		put_reg(ssp_pkg::CFG_VIEW_DIR_Y, nc.view_dir_y);
		put_reg(ssp_pkg::CFG_PLANE_X, nc.plane_x);
		put_reg(ssp_pkg::CFG_PLANE_Y, nc.plane_y);
		cfg_valid <= 1'b0;
		camera = nc;
		camera_loads++;
	endtask

	// ------------------------------------------------------------------
	// Result side: stall pattern and checker
	// ------------------------------------------------------------------
	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			stall_cycle++;
			// Periodically pick a new random stall pattern
			if (stall_cycle % 200 == 0) begin
				stall_pat = stall_pat_t'($urandom_range(0, 3));
			end
			if (quiet_mode) begin
				res_stall <= 1'b0;
			end else begin
				case (stall_pat)
					STALL_NONE: begin
						res_stall <= 1'b0;
					end
					STALL_LIGHT: begin
						res_stall <= ($urandom_range(0, 3) == 0);
					end
					STALL_PERIODIC: begin
						res_stall <= ((stall_cycle % 9) < 4);
					end
					default: begin
						res_stall <= ($urandom_range(0, 3) != 0);
					end
				endcase
			end
		end
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		ssp_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_views.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result with no request pending at %0t", $time);
				end
			end else begin
				want = pending_views.pop_front();
				check_field("visible", want.visible, res.visible);
				check_field("depth", want.depth, res.depth);
				check_field("center_column", want.center_column, res.center_column);
				check_field("sprite_size", want.sprite_size, res.sprite_size);
				check_field("first_column", want.first_column, res.first_column);
				check_field("end_column", want.end_column, res.end_column);
				check_field("first_row", want.first_row, res.first_row);
				check_field("end_row", want.end_row, res.end_row);
				if (want.visible) begin
					visible_seen++;
				end
				results_seen++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Camera at reset: depth equals dx, lateral offset about 1.5 dy
	task automatic test_reset_camera();
		send_sprite('{16'sd1280, 16'sd0});
		send_sprite('{16'sd256, 16'sd0});
		send_sprite('{16'sd1, 16'sd0});
		send_sprite('{16'sd1, 16'sd1});
		send_sprite('{16'sd128, 16'sd2000});
		send_sprite('{16'sd128, -16'sd2000});
		send_sprite('{16'sd256, 16'sd32767});
		send_sprite('{16'sd1, 16'sd32767});
		send_sprite('{16'sd0, 16'sd0});
		send_sprite('{-16'sd1280, 16'sd500});
		send_sprite('{-16'sd32768, 16'sd0});
		send_sprite('{16'sd32767, 16'sd0});
		send_sprite('{16'sd32767, 16'sd32767});
		send_sprite('{-16'sd32768, -16'sd32768});
		send_sprite('{16'sd32767, -16'sd32768});
		send_sprite('{-16'sd32768, 16'sd32767});
		settle();
	endtask

	// Register extremes, a parallel basis and saturating offsets
	task automatic test_camera_extremes();
		load_camera('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		send_sprite('{16'sd32767, -16'sd32768});
		send_sprite('{16'sd0, 16'sd0});
		load_camera('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
		send_sprite('{-16'sd32768, 16'sd32767});
		load_camera('{16'sd0, 16'sd0, 16'sd16384, 16'sd0, -16'sd8192, 16'sd0});
		send_sprite('{16'sd1280, 16'sd0});
		load_camera('{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF});
		send_sprite('{16'sd32767, -16'sd32768});
		send_sprite('{-16'sd32768, 16'sd32767});
		send_sprite('{16'sd0, 16'sd0});
		settle();
	endtask

	// Random cameras, each with a batch of mostly nearby sprites
	task automatic test_random_projection();
		for (int phase = 0; phase < 8; phase++) begin
			load_camera(random_camera());
			for (int n = 0; n < 145; n++) begin
				send_sprite(random_sprite(camera));
			end
		end
		settle();
	endtask

	// Full rate with no idling on either side
	task automatic test_back_to_back();
		quiet_mode = 1'b1;
		load_camera('{16'sd640, 16'sd1792, 16'sd0, -16'sd16384, 16'sd10813, 16'sd0});
		for (int n = 0; n < 120; n++) begin
			send_sprite(random_sprite(camera));
		end
		settle();
		quiet_mode = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = ssp_pkg::CFG_PLAYER_X;
		cfg_data  = '0;
		camera    = ssp_pkg::CAM_CFG_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_camera();
		test_camera_extremes();
		test_random_projection();
		test_back_to_back();

		// Drain and watch for stray results
		settle();
		repeat (60) @(posedge clk);

		$display("%0d sprites sent, %0d results checked (%0d visible) over %0d camera loads",
			sprites_sent, results_seen, visible_seen, camera_loads);
		$display("%0d mismatches, %0d results still pending", mismatches, pending_views.size());
		if (mismatches == 0 && pending_views.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== sprite_screen_projection.f =====
hdl/ssp_pkg.sv
hdl/ssp_div.sv
hdl/ssp_xform.sv
hdl/ssp_proj.sv
hdl/sprite_screen_projection.sv
dv/tb.sv
